>>> src/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// Shared opcodes and fixed port widths for the Fenwick tree engine.
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int OPCODE_W = 2;
  localparam int ADD_IDX_W = 10;
  localparam int RANGE_W = 11;
  localparam int IN_VALUE_W = 32;
  localparam int SUM_W = 32;
  localparam int FOUND_W = 11;

  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam opcode_t OP_ADD = 2'd0;
  localparam opcode_t OP_QUERY = 2'd1;
  localparam opcode_t OP_SEARCH = 2'd2;
  localparam opcode_t OP_NONE = 2'd3;

endpackage

>>> src/fenwick_tree_engine_core.sv
// ----------------------------------------------------------------------------
// fenwick_tree_engine_core
// Unused opcodes and out-of-range adds finish without visiting the tree; add,
// range query and search walk it. Each tree node visited takes a read state
// and a use state on the one synchronous tree memory; one transaction is
// worked at a time. The result strobe is registered, rising in the cycle
// after the closing check with busy already low, so the next start can be
// taken then; the receiver cannot stall. After reset busy stays high while
// the memory is cleared.
// ----------------------------------------------------------------------------
module fenwick_tree_engine_core
  import fte_pkg::*;
#(
  parameter int SIZE = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [OPCODE_W-1:0]         in_opcode,
  input  logic [ADD_IDX_W-1:0]        in_add_index,
  input  logic [RANGE_W-1:0]          in_range_left,
  input  logic [RANGE_W-1:0]          in_range_right,
  input  logic signed [IN_VALUE_W-1:0] in_value,
  output logic                        out_valid,
  output logic signed [SUM_W-1:0]     out_sum_result,
  output logic [FOUND_W-1:0]          out_found_index
);

  localparam int AW = $clog2(SIZE);
  localparam int PW = $clog2(SIZE + 1) + 1;
  localparam int VW = VALUE_WIDTH;
  localparam int EXTW = (VW > IN_VALUE_W) ? VW : IN_VALUE_W;
  localparam int FEXTW = (PW > FOUND_W) ? PW : FOUND_W;
  localparam logic [PW-1:0] STEP0 = {1'b1, {(PW-1){1'b0}}};
  localparam logic [PW-1:0] SIZE_P = PW'(SIZE);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ACHK  = 4'd2;
  localparam logic [3:0] ST_AWR   = 4'd3;
  localparam logic [3:0] ST_QCHK  = 4'd4;
  localparam logic [3:0] ST_QACC  = 4'd5;
  localparam logic [3:0] ST_SCHK  = 4'd6;
  localparam logic [3:0] ST_SCMP  = 4'd7;

  logic [VW-1:0] tree_nodes_mem [SIZE];

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] left_r, left_nxt;
  logic [PW-1:0] found_r, found_nxt;
  logic [PW-1:0] step_r, step_nxt;
  logic          phase_r, phase_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [VW-1:0] acc_r, acc_nxt;
  logic [VW-1:0] first_r, first_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [FOUND_W-1:0] found_out_r, found_out_nxt;

  logic [VW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  logic [EXTW-1:0] value_ext;
  logic [VW-1:0]   value_in;
  logic [PW-1:0]   left_sat;
  logic [PW-1:0]   right_sat;
  logic [PW-1:0]   pos_m1;
  logic [PW-1:0]   probe;
  logic [PW-1:0]   probe_m1;
  logic [PW-1:0]   low_bit;
  logic [VW-1:0]   diff;
  logic [EXTW-1:0] diff_ext;
  logic [FEXTW-1:0] found_ext;
  logic            accept;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_sum_result  = sum_r;
  assign out_found_index = found_out_r;

  assign value_ext = EXTW'(in_value);
  assign value_in  = value_ext[VW-1:0];
  assign left_sat  = (32'(in_range_left) > SIZE) ? SIZE_P : PW'(in_range_left);
  assign right_sat = (32'(in_range_right) > SIZE) ? SIZE_P : PW'(in_range_right);

  assign pos_m1   = pos_r - PW'(1);
  assign probe    = found_r + step_r;
  assign probe_m1 = probe - PW'(1);
  assign low_bit  = pos_r & (~pos_r + PW'(1));
  assign rd_addr  = (state_r == ST_SCHK) ? probe_m1[AW-1:0] : pos_m1[AW-1:0];

  assign diff      = first_r - acc_r;
  assign diff_ext  = EXTW'(diff);
  assign found_ext = FEXTW'(found_r);

  // Tree store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_nodes_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= tree_nodes_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    found_nxt     = found_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    first_nxt     = first_r;
    sum_nxt       = sum_r;
    found_out_nxt = found_out_r;
    wr_en         = 1'b0;
    wr_addr       = pos_m1[AW-1:0];
    wr_data       = rd_data_r + val_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          sum_nxt       = '0;
          found_out_nxt = '0;
          val_nxt       = value_in;
          acc_nxt       = '0;
          found_nxt     = '0;
          step_nxt      = STEP0;
          phase_nxt     = 1'b0;
          left_nxt      = left_sat;
          unique case (in_opcode)
            OP_ADD: begin
              if (32'(in_add_index) < SIZE) begin
                pos_nxt   = PW'(in_add_index) + PW'(1);
                state_nxt = ST_ACHK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              pos_nxt   = right_sat;
              state_nxt = ST_QCHK;
            end
            OP_SEARCH: begin
              state_nxt = ST_SCHK;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ACHK: begin
        if (pos_r > SIZE_P) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_AWR;
        end
      end
      ST_AWR: begin
        // write back the node read last cycle, then climb to the parent
        wr_en     = 1'b1;
        pos_nxt   = pos_r + low_bit;
        state_nxt = ST_ACHK;
      end
      ST_QCHK: begin
        if (pos_r == '0) begin
          if (!phase_r) begin
            first_nxt = acc_r;
            acc_nxt   = '0;
            pos_nxt   = left_r;
            phase_nxt = 1'b1;
          end else begin
            sum_nxt       = diff_ext[SUM_W-1:0];
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_QACC;
        end
      end
      ST_QACC: begin
        acc_nxt   = acc_r + rd_data_r;
        pos_nxt   = pos_r - low_bit;
        state_nxt = ST_QCHK;
      end
      ST_SCHK: begin
        if (step_r == '0) begin
          found_out_nxt = found_ext[FOUND_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (probe <= SIZE_P) begin
          state_nxt = ST_SCMP;
        end else begin
          step_nxt = step_r >> 1;
        end
      end
      ST_SCMP: begin
        if ($signed(rd_data_r) < $signed(val_r)) begin
          val_nxt   = val_r - rd_data_r;
          found_nxt = probe;
        end
        step_nxt  = step_r >> 1;
        state_nxt = ST_SCHK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    left_r      <= left_nxt;
    found_r     <= found_nxt;
    step_r      <= step_nxt;
    phase_r     <= phase_nxt;
    val_r       <= val_nxt;
    acc_r       <= acc_nxt;
    first_r     <= first_nxt;
    sum_r       <= sum_nxt;
    found_out_r <= found_out_nxt;
  end

endmodule

>>> src/fte_checker.sv
// ----------------------------------------------------------------------------
// fte_sva
// Port-level checks on the Fenwick tree engine's command and result timing.
// ----------------------------------------------------------------------------
module fte_sva
  import fte_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [SUM_W-1:0]   out_sum_result,
  input logic [FOUND_W-1:0] out_found_index
);

  // an accepted transaction either finishes at once or keeps the engine busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither busy nor finished");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction in flight");

  // only one of the two result fields can be meaningful
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sum_result == '0 || out_found_index == '0))
    else $error("both result fields nonzero");

endmodule

bind fenwick_tree_engine_core fte_sva u_fte_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_sum_result  (out_sum_result),
  .out_found_index (out_found_index)
);
